@@ design/encoder_position_pid_unit_macros.svh @@
// Assertion macros shared by the checker of the encoder position PID unit.
// Depends on signals named clk and rst_n in the scope where they are used.
`ifndef ENCODER_POSITION_PID_UNIT_MACROS_SVH
`define ENCODER_POSITION_PID_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EPID_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EPID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/epid_pkg.sv @@
// Shared types and constants of the encoder position PID unit.
// Used by the queue, the front end, the back end, the top level and the checker.
package epid_pkg;

  // Width of the wrapping position count.
  localparam int COUNT_BITS = 24;

  // Opcodes of an input word.
  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes.
  localparam int          CFG_IDX_W   = 3;
  localparam logic [2:0]  CFG_GAIN_P  = 3'd0;
  localparam logic [2:0]  CFG_GAIN_I  = 3'd1;
  localparam logic [2:0]  CFG_GAIN_D  = 3'd2;
  localparam logic [2:0]  CFG_DPC     = 3'd3;
  localparam int          CFG_DATA_W  = 16;

  // Reset values of the configuration registers.
  localparam logic [15:0] GAIN_P_RST = 16'd8192;
  localparam logic [15:0] GAIN_I_RST = 16'd410;
  localparam logic [15:0] GAIN_D_RST = 16'd410;
  localparam logic [7:0]  DPC_RST    = 8'd6;

  // Tick queue between the front end and the back end.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Shared multiplier: signed 25 bit operand times non-negative 17 bit operand.
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int HALF_W  = 24;
  localparam int TOT_W   = 68;
  localparam int N_PASS  = 6;
  localparam int PASS_W  = 3;

  // Configuration seen by the back end.
  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [7:0]  dpc;
  } cfg_t;

  // A control tick waiting in the queue, with the count it must see.
  typedef struct packed {
    logic                    target_valid;
    logic signed [15:0]      target_in;
    logic [COUNT_BITS-1:0]   count;
  } tick_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    B_IDLE,
    B_ANGLE,
    B_ERR,
    B_MUL,
    B_FIN
  } back_state_t;

endpackage

@@ design/epid_queue.sv @@
// Two-entry queue of control ticks between the front end and the back end.
// Depends on epid_pkg for the tick type and queue sizes.
module epid_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  epid_pkg::tick_t push_data,
  input  logic           pop,
  output epid_pkg::tick_t pop_data,
  output logic           full,
  output logic           empty
);
  import epid_pkg::*;

  tick_t               entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]  fill_r, fill_nxt;

  assign full     = (fill_r == Q_CNT_W'(Q_DEPTH));
  assign empty    = (fill_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ design/epid_front.sv @@
// Front end: accepts input words, applies encoder edges to the position count
// and queues control ticks with a snapshot of the count. Depends on epid_pkg.
module epid_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_opcode,
  input  logic            in_chan_a,
  input  logic            in_chan_b,
  input  logic            in_target_valid,
  input  logic signed [15:0] in_target_in,
  input  logic            q_full,
  output logic            q_push,
  output epid_pkg::tick_t q_push_data
);
  import epid_pkg::*;

  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  accept;

  // A word is taken whenever the queue has room for a tick.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Ticks carry the count as it stands when they arrive.
  assign q_push                   = accept && (in_opcode == OP_TICK);
  assign q_push_data.target_valid = in_target_valid;
  assign q_push_data.target_in    = in_target_in;
  assign q_push_data.count        = count_r;

  // x2 decoding: up when the channels differ, down when they agree.
  always_comb begin
    count_nxt = count_r;
    if (accept && (in_opcode == OP_EDGE)) begin
      if (in_chan_a != in_chan_b) begin
        count_nxt = count_r + 1'b1;
      end else begin
        count_nxt = count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

@@ design/epid_back.sv @@
// Back end: takes queued ticks, measures the angle, updates the error state and
// forms the PID sum on one shared multiplier. Depends on epid_pkg.
module epid_back (
  input  logic               clk,
  input  logic               rst_n,
  input  epid_pkg::cfg_t     cfg,
  input  logic               q_empty,
  input  epid_pkg::tick_t    q_pop_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] out_pid_output,
  output logic signed [31:0] out_current_angle,
  output logic signed [15:0] out_target_angle
);
  import epid_pkg::*;

  back_state_t state_r, state_nxt;

  // Controller state.
  logic signed [15:0]    held_r;
  logic signed [47:0]    esum_r;
  logic signed [32:0]    last_err_r;

  // Working registers of the tick in progress.
  logic [COUNT_BITS-1:0] count_r;
  logic signed [31:0]    angle_r;
  logic signed [32:0]    err_r;
  logic signed [33:0]    diff_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                  hi_r;
  logic [PASS_W-1:0]     pass_r;
  logic signed [TOT_W-1:0] total_r;

  // Output register.
  logic                  out_valid_r;
  logic signed [47:0]    out_pid_r;
  logic signed [31:0]    out_angle_r;
  logic signed [15:0]    out_target_r;

  // Control decoded from the state.
  logic                  issue_mul;
  logic                  accum;
  logic                  out_load;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  // Arithmetic of the error step.
  logic signed [31:0]    angle_c;
  logic signed [32:0]    err_c;
  logic signed [48:0]    sum49_c;
  logic signed [47:0]    sum_c;
  logic signed [33:0]    diff_c;
  logic signed [47:0]    term_v;
  logic [15:0]           term_g;
  logic signed [TOT_W-1:0] addend_c;
  logic signed [47:0]    total_sat_c;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (!q_empty) state_nxt = B_ANGLE;
      B_ANGLE: state_nxt = B_ERR;
      B_ERR:   state_nxt = B_MUL;
      B_MUL:   if (pass_r == PASS_W'(N_PASS)) state_nxt = B_FIN;
      B_FIN:   if (out_load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_pop     = 1'b0;
    issue_mul = 1'b0;
    accum     = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      B_IDLE:  q_pop = !q_empty;
      B_ANGLE: issue_mul = 1'b1;
      B_ERR:   ;
      B_MUL: begin
        issue_mul = (pass_r != PASS_W'(N_PASS));
        accum     = (pass_r != '0);
      end
      B_FIN:   out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // Term selection: pairs of passes cover the P, I and D terms, low half first.
  always_comb begin
    unique case (pass_r[2:1])
      2'd0: begin
        term_v = {{15{err_r[32]}}, err_r};
        term_g = cfg.gain_p;
      end
      2'd1: begin
        term_v = esum_r;
        term_g = cfg.gain_i;
      end
      default: begin
        term_v = {{14{diff_r[33]}}, diff_r};
        term_g = cfg.gain_d;
      end
    endcase
  end

  // Multiplier operands: the count in the angle step, otherwise a half of a term.
  always_comb begin
    if (state_r == B_ANGLE) begin
      mul_a = {{(MUL_A_W-COUNT_BITS){count_r[COUNT_BITS-1]}}, count_r};
      mul_b = {{(MUL_B_W-8){1'b0}}, cfg.dpc};
    end else if (pass_r[0]) begin
      mul_a = {term_v[47], term_v[47:HALF_W]};
      mul_b = {{(MUL_B_W-16){1'b0}}, term_g};
    end else begin
      mul_a = {1'b0, term_v[HALF_W-1:0]};
      mul_b = {{(MUL_B_W-16){1'b0}}, term_g};
    end
  end

  assign mul_p = mul_a * mul_b;

  // Error, saturating sum and difference.
  always_comb begin
    angle_c = prod_r[31:0];
    err_c   = {{17{held_r[15]}}, held_r} - {angle_c[31], angle_c};
    sum49_c = {esum_r[47], esum_r} + {{16{err_c[32]}}, err_c};
    if (sum49_c[48] != sum49_c[47]) begin
      sum_c = sum49_c[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      sum_c = sum49_c[47:0];
    end
    diff_c = {err_c[32], err_c} - {last_err_r[32], last_err_r};
  end

  // Partial product aligned for the accumulator.
  always_comb begin
    if (hi_r) begin
      addend_c = {{(TOT_W-PROD_W-HALF_W){prod_r[PROD_W-1]}}, prod_r, {HALF_W{1'b0}}};
    end else begin
      addend_c = {{(TOT_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  // Clamp the exact sum to 48 bits signed.
  always_comb begin
    if ((&total_r[TOT_W-1:47]) || !(|total_r[TOT_W-1:47])) begin
      total_sat_c = total_r[47:0];
    end else if (total_r[TOT_W-1]) begin
      total_sat_c = {1'b1, 47'd0};
    end else begin
      total_sat_c = {1'b0, {47{1'b1}}};
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      held_r      <= '0;
      esum_r      <= '0;
      last_err_r  <= '0;
      pass_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop && q_pop_data.target_valid) begin
        held_r <= q_pop_data.target_in;
      end
      if (state_r == B_ERR) begin
        esum_r     <= sum_c;
        last_err_r <= err_c;
        pass_r     <= '0;
      end else if (state_r == B_MUL) begin
        pass_r <= pass_r + 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      count_r <= q_pop_data.count;
    end
    if (issue_mul) begin
      prod_r <= mul_p;
      hi_r   <= pass_r[0] && (state_r == B_MUL);
    end
    if (state_r == B_ERR) begin
      angle_r <= angle_c;
      err_r   <= err_c;
      diff_r  <= diff_c;
      total_r <= '0;
    end else if (accum) begin
      total_r <= total_r + addend_c;
    end
    if (out_load) begin
      out_pid_r    <= total_sat_c;
      out_angle_r  <= angle_r;
      out_target_r <= held_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pid_output    = out_pid_r;
  assign out_current_angle = out_angle_r;
  assign out_target_angle  = out_target_r;

endmodule

@@ design/encoder_position_pid_unit.sv @@
// Top level of the encoder position PID unit: configuration registers, front
// end, tick queue and back end. Depends on epid_pkg and the three submodules.
//
//   Channel   Direction  Handshake             Word
//   in_       input      in_valid / in_ready   opcode, channel levels, target
//   out_      output     out_valid / out_ready PID output, angle, target
//   cfg_      input      cfg_we                register index and data
//
// An encoder edge is handled in the front end and leaves no result.
// A control tick goes through these steps in the back end: queue read, angle,
// error step, six passes of the shared 25x17 multiplier, a last accumulate
// and a final clamp.
// Reset clears the count, the controller state, the queue and the output valid flag.
// The queue holds two ticks, so input keeps flowing while a result waits, until the queue is full.
module encoder_position_pid_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_opcode,
  input  logic                              in_chan_a,
  input  logic                              in_chan_b,
  input  logic                              in_target_valid,
  input  logic signed [15:0]                in_target_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [47:0]                out_pid_output,
  output logic signed [31:0]                out_current_angle,
  output logic signed [15:0]                out_target_angle,
  input  logic                              cfg_we,
  input  logic [epid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [epid_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import epid_pkg::*;

  cfg_t  cfg_r;
  logic  q_push, q_pop, q_full, q_empty;
  tick_t q_push_data, q_pop_data;

  // Configuration registers; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p <= GAIN_P_RST;
      cfg_r.gain_i <= GAIN_I_RST;
      cfg_r.gain_d <= GAIN_D_RST;
      cfg_r.dpc    <= DPC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN_P: cfg_r.gain_p <= cfg_data;
        CFG_GAIN_I: cfg_r.gain_i <= cfg_data;
        CFG_GAIN_D: cfg_r.gain_d <= cfg_data;
        CFG_DPC:    cfg_r.dpc    <= cfg_data[7:0];
        default:    ;
      endcase
    end
  end

  epid_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_chan_a       (in_chan_a),
    .in_chan_b       (in_chan_b),
    .in_target_valid (in_target_valid),
    .in_target_in    (in_target_in),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_push_data     (q_push_data)
  );

  epid_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  epid_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_pop_data        (q_pop_data),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pid_output    (out_pid_output),
    .out_current_angle (out_current_angle),
    .out_target_angle  (out_target_angle)
  );

endmodule

@@ design/epid_checker.sv @@
// Port-level checker of the encoder position PID unit and its bind statement.
// Depends on epid_pkg and encoder_position_pid_unit_macros.svh.
`include "encoder_position_pid_unit_macros.svh"

module epid_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_opcode,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [47:0] out_pid_output
);
  import epid_pkg::*;

  // A stalled result word stays offered.
  `EPID_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped")

  // A stalled result word keeps its value.
  `EPID_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_pid_output), "result word changed while stalled")

  // No result is offered straight after reset.
  `EPID_ASSERT_NOW(a_reset_quiet, $past(!rst_n), !out_valid, "result offered after reset")

  // The input stalls only when a tick has just filled the queue.
  `EPID_ASSERT_NOW(a_stall_cause, $fell(in_ready), $past(in_valid && in_ready && (in_opcode == OP_TICK)), "input stalled without a queued tick")

endmodule

bind encoder_position_pid_unit epid_checker u_epid_checker (.*);
